// ----- rtl/core/lrd_pkg.sv -----
// Shared types, codes and the CRC-32C byte update for the log record deframer.
// No dependencies; imported by lrd_parser and log_record_deframer_crc32c.
package lrd_pkg;

    // Key and value byte counters use this many low bits of the header lengths.
    localparam int unsigned LENGTH_WIDTH = 32;

    localparam logic [31:0] CRC_POLY = 32'h82F6_3B78;
    localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

    // Record section of a byte; doubles as the parser phase.
    typedef enum logic [2:0] {
        SEC_TYPE = 3'd0,
        SEC_KLEN = 3'd1,
        SEC_VLEN = 3'd2,
        SEC_TS   = 3'd3,
        SEC_KEY  = 3'd4,
        SEC_VAL  = 3'd5,
        SEC_CRC  = 3'd6
    } t_section;

    typedef enum logic [2:0] {
        ST_BUSY    = 3'd0,
        ST_OK      = 3'd1,
        ST_BAD_CRC = 3'd2,
        ST_TRUNC   = 3'd3,
        ST_DISCARD = 3'd4
    } t_status;

    typedef struct packed {
        logic [63:0] record_timestamp;
        logic [31:0] value_size;
        logic [31:0] key_size;
        logic [7:0]  record_type;
        t_status     status;
        logic        record_done;
        logic        header_done;
        t_section    section;
        logic [7:0]  data_byte;
    } t_lrd_result;

    // Reflected CRC-32C, one byte, bit at a time.
    function automatic logic [31:0] lrd_crc_byte(input logic [31:0] acc,
                                                 input logic [7:0]  b);
        logic [31:0] c;
        c = acc ^ {24'd0, b};
        for (int i = 0; i < 8; i++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

// ----- rtl/core/log_record_deframer_crc32c.sv -----
// Top level of the CRC-32C checked log record deframer: stream ports,
// result register with skid stage. Depends on lrd_pkg and lrd_parser.
//
//  channel  | dir | tdata                                 | tuser   | tlast
//  ---------+-----+---------------------------------------+---------+------------
//  s_axis   | in  | [7:0] stream byte                     | -       | stream end
//  m_axis   | out | byte, header_done, status, header     | section | record_done
//
// One byte beat per clock, sustained while the skid stage is free; each accepted
// beat yields one result beat, registered in the result register or the skid stage.
// The byte-wide CRC update and the length compare sit between the parser state and the result register.
// Reset is synchronous, active low; it returns the parser to the type byte.
// A stalled result beat is held in the result register; one more beat lands
// in the skid stage, and o_s_axis_tready drops only while the skid is full.
module log_record_deframer_crc32c (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    input  logic [7:0]   i_s_axis_tdata,   // [7:0] stream_byte
    input  logic         i_s_axis_tlast,   // stream_last
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    // [7:0] data_byte, [8] header_done, [11:9] status, [19:12] record_type,
    // [51:20] key_size, [83:52] value_size, [147:84] record_timestamp, rest 0
    output logic [151:0] o_m_axis_tdata,
    output logic [2:0]   o_m_axis_tuser,   // [2:0] section
    output logic         o_m_axis_tlast    // record_done
);
    import lrd_pkg::*;

    t_lrd_result res;
    t_lrd_result r_out;
    t_lrd_result r_skd;
    logic        r_out_vld;
    logic        r_skd_vld;
    logic        s_accept;
    logic        m_take;

    // accept whenever the skid stage is free
    assign o_s_axis_tready = !r_skd_vld;
    assign s_accept        = i_s_axis_tvalid && !r_skd_vld;
    assign m_take          = r_out_vld && i_m_axis_tready;

    lrd_parser u_parser (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (s_accept),
        .i_byte   (i_s_axis_tdata),
        .i_last   (i_s_axis_tlast),
        .o_res    (res)
    );

    // Result valid flags: advance skid into the result register on a take.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
            r_skd_vld <= 1'b0;
        end else if (m_take) begin
            if (r_skd_vld) begin
                r_skd_vld <= 1'b0;
            end else begin
                r_out_vld <= s_accept;
            end
        end else if (!r_out_vld) begin
            r_out_vld <= s_accept;
        end else if (s_accept) begin
            r_skd_vld <= 1'b1;
        end
    end

    // Result payload: no reset needed.
    always_ff @(posedge i_clk) begin
        if (m_take) begin
            if (r_skd_vld) begin
                r_out <= r_skd;
            end else if (s_accept) begin
                r_out <= res;
            end
        end else if (!r_out_vld) begin
            if (s_accept) begin
                r_out <= res;
            end
        end else if (s_accept) begin
            r_skd <= res;
        end
    end

    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tuser  = r_out.section;
    assign o_m_axis_tlast  = r_out.record_done;
    assign o_m_axis_tdata  = {4'd0,
                              r_out.record_timestamp,
                              r_out.value_size,
                              r_out.key_size,
                              r_out.record_type,
                              r_out.status,
                              r_out.header_done,
                              r_out.data_byte};

`ifndef ASSERT_OFF
    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skd_vld |-> r_out_vld)
        else $error("skid stage holds a beat while the result register is empty");

    a_end_status_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && (r_out.status == ST_OK || r_out.status == ST_BAD_CRC
                            || r_out.status == ST_TRUNC) |-> o_m_axis_tlast)
        else $error("record end status without record_done");

    a_busy_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && r_out.status == ST_BUSY |-> !o_m_axis_tlast)
        else $error("record_done flagged with status in progress");

    a_header_in_ts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && r_out.header_done |-> o_m_axis_tuser == SEC_TS)
        else $error("header_done outside the timestamp section");
`endif

endmodule

// ----- rtl/core/lrd_parser.sv -----
// Record parser: phase state machine, header capture and CRC-32C check.
// Depends on lrd_pkg. Produces the result for the current byte combinationally.
module lrd_parser (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_accept,
    input  logic [7:0]           i_byte,
    input  logic                 i_last,
    output lrd_pkg::t_lrd_result o_res
);
    import lrd_pkg::*;

    t_section                r_phase,  n_phase;
    logic [LENGTH_WIDTH-1:0] r_cnt,    n_cnt;
    logic [31:0]             r_crc,    n_crc;
    logic [7:0]              r_type,   n_type;
    logic [31:0]             r_key,    n_key;
    logic [31:0]             r_val,    n_val;
    logic [63:0]             r_ts,     n_ts;
    logic [31:0]             r_rcv,    n_rcv;
    logic                    r_failed, n_failed;

    logic [LENGTH_WIDTH-1:0] cnt_inc;
    logic [31:0]             crc_upd;
    logic                    key_nz;
    logic                    val_nz;

    assign cnt_inc = r_cnt + 1'b1;
    assign crc_upd = lrd_crc_byte(r_crc, i_byte);
    assign key_nz  = |r_key[LENGTH_WIDTH-1:0];
    assign val_nz  = |r_val[LENGTH_WIDTH-1:0];

    always_comb begin
        n_phase  = r_phase;
        n_cnt    = r_cnt;
        n_crc    = r_crc;
        n_type   = r_type;
        n_key    = r_key;
        n_val    = r_val;
        n_ts     = r_ts;
        n_rcv    = r_rcv;
        n_failed = r_failed;

        o_res.data_byte   = i_byte;
        o_res.section     = r_phase;
        o_res.header_done = 1'b0;
        o_res.record_done = 1'b0;
        o_res.status      = ST_BUSY;

        if (r_failed) begin
            // discard until stream end
            o_res.section     = SEC_TYPE;
            o_res.record_done = i_last;
            o_res.status      = ST_DISCARD;
        end else begin
            unique case (r_phase)
                SEC_KLEN: begin
                    n_crc = crc_upd;
                    n_key[{r_cnt[1:0], 3'b000} +: 8] = i_byte;
                    n_cnt = cnt_inc;
                    if (r_cnt[1:0] == 2'd3) begin
                        n_cnt   = '0;
                        n_phase = SEC_VLEN;
                    end
                end
                SEC_VLEN: begin
                    n_crc = crc_upd;
                    n_val[{r_cnt[1:0], 3'b000} +: 8] = i_byte;
                    n_cnt = cnt_inc;
                    if (r_cnt[1:0] == 2'd3) begin
                        n_cnt   = '0;
                        n_phase = SEC_TS;
                    end
                end
                SEC_TS: begin
                    n_crc = crc_upd;
                    n_ts[{r_cnt[2:0], 3'b000} +: 8] = i_byte;
                    n_cnt = cnt_inc;
                    if (r_cnt[2:0] == 3'd7) begin
                        n_cnt             = '0;
                        o_res.header_done = 1'b1;
                        n_phase = key_nz ? SEC_KEY : (val_nz ? SEC_VAL : SEC_CRC);
                    end
                end
                SEC_KEY: begin
                    n_crc = crc_upd;
                    n_cnt = cnt_inc;
                    if (cnt_inc == r_key[LENGTH_WIDTH-1:0]) begin
                        n_cnt   = '0;
                        n_phase = val_nz ? SEC_VAL : SEC_CRC;
                    end
                end
                SEC_VAL: begin
                    n_crc = crc_upd;
                    n_cnt = cnt_inc;
                    if (cnt_inc == r_val[LENGTH_WIDTH-1:0]) begin
                        n_cnt   = '0;
                        n_phase = SEC_CRC;
                    end
                end
                SEC_CRC: begin
                    n_rcv[{r_cnt[1:0], 3'b000} +: 8] = i_byte;
                    n_cnt = cnt_inc;
                    if (r_cnt[1:0] == 2'd3) begin
                        o_res.record_done = 1'b1;
                        if ({i_byte, r_rcv[23:0]} == ~r_crc) begin
                            o_res.status = ST_OK;
                        end else begin
                            o_res.status = ST_BAD_CRC;
                            n_failed     = 1'b1;
                        end
                        n_phase = SEC_TYPE;
                        n_cnt   = '0;
                        n_crc   = CRC_INIT;
                    end
                end
                default: begin
                    // type byte; unused phase code lands here too
                    o_res.section = SEC_TYPE;
                    n_type  = i_byte;
                    n_key   = '0;
                    n_val   = '0;
                    n_ts    = '0;
                    n_rcv   = '0;
                    n_crc   = lrd_crc_byte(CRC_INIT, i_byte);
                    n_cnt   = '0;
                    n_phase = SEC_KLEN;
                end
            endcase
            if (i_last) begin
                o_res.record_done = 1'b1;
                if (o_res.status == ST_BUSY) begin
                    o_res.status = ST_TRUNC;
                end
            end
        end

        o_res.record_type      = n_type;
        o_res.key_size         = n_key;
        o_res.value_size       = n_val;
        o_res.record_timestamp = n_ts;

        // restart from reset after the final stream byte
        if (i_last) begin
            n_phase  = SEC_TYPE;
            n_cnt    = '0;
            n_crc    = CRC_INIT;
            n_type   = '0;
            n_key    = '0;
            n_val    = '0;
            n_ts     = '0;
            n_rcv    = '0;
            n_failed = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= SEC_TYPE;
            r_cnt    <= '0;
            r_crc    <= CRC_INIT;
            r_type   <= '0;
            r_key    <= '0;
            r_val    <= '0;
            r_ts     <= '0;
            r_rcv    <= '0;
            r_failed <= 1'b0;
        end else if (i_accept) begin
            r_phase  <= n_phase;
            r_cnt    <= n_cnt;
            r_crc    <= n_crc;
            r_type   <= n_type;
            r_key    <= n_key;
            r_val    <= n_val;
            r_ts     <= n_ts;
            r_rcv    <= n_rcv;
            r_failed <= n_failed;
        end
    end

endmodule
